/* design/domain_idle_cpu_picker_unit_defines.svh */
// ----------------------------------------------------------------------------
// Idle CPU picker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DOMAIN_IDLE_CPU_PICKER_UNIT_DEFINES_SVH
`define DOMAIN_IDLE_CPU_PICKER_UNIT_DEFINES_SVH

// Same-cycle implication
`define DICP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dicp: same-cycle check failed");

// Next-cycle implication
`define DICP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dicp: next-cycle check failed");

`endif

/* design/dicp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle CPU picker package
// Shared widths, codes, beat structs and the lowest-set-bit encoder.
// ----------------------------------------------------------------------------
package dicp_pkg;

    localparam int MAX_CPUS  = 64;
    localparam int CPU_W     = $clog2(MAX_CPUS);
    localparam int SLICE_W   = 30;
    localparam int ACTIVE_W  = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_MARK   = 2'd0,
        OP_SELECT = 2'd1,
        OP_KICK   = 2'd2
    } opcode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_SLICE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_SLICE = 3'd4;

    localparam logic signed [CPU_W:0] CPU_NONE = '1;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [CPU_W:0]   cpu_index;
        logic                    task_domain;
        logic [MAX_CPUS-1:0]     allowed_mask;
    } pick_req_t;

    typedef struct packed {
        logic signed [CPU_W:0]   chosen_cpu;
        logic                    claimed;
        logic                    stolen;
        logic [SLICE_W-1:0]      slice_ns;
    } pick_rsp_t;

    typedef struct packed {
        logic [ACTIVE_W-1:0]     active_cpus;
        logic [MAX_CPUS-1:0]     little_cpu_mask;
        logic                    strict_mode;
        logic [SLICE_W-1:0]      big_slice_ns;
        logic [SLICE_W-1:0]      little_slice_ns;
    } pick_cfg_t;

    typedef struct packed {
        logic                    found;
        logic [CPU_W-1:0]        index;
    } lowest_t;

    // Priority encoder: lowest set bit of a CPU vector
    function automatic lowest_t lowest_set(input logic [MAX_CPUS-1:0] vec);
        lowest_t res;
        res = '0;
        for (int i = MAX_CPUS - 1; i >= 0; i--) begin
            if (vec[i])
            begin
                res.found = 1'b1;
                res.index = CPU_W'(i);
            end
        end
        return res;
    endfunction

endpackage

/* design/dicp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle CPU picker channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dicp_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             opcode;
    logic signed [dicp_pkg::CPU_W:0]        cpu_index;
    logic                                   task_domain;
    logic [dicp_pkg::MAX_CPUS-1:0]          allowed_mask;

    modport source (output valid, opcode, cpu_index, task_domain, allowed_mask,
                    input ready);
    modport sink   (input valid, opcode, cpu_index, task_domain, allowed_mask,
                    output ready);
endinterface

interface dicp_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dicp_pkg::CPU_W:0]        chosen_cpu;
    logic                                   claimed;
    logic                                   stolen;
    logic [dicp_pkg::SLICE_W-1:0]           slice_ns;

    modport source (output valid, chosen_cpu, claimed, stolen, slice_ns,
                    input ready);
    modport sink   (input valid, chosen_cpu, claimed, stolen, slice_ns,
                    output ready);
endinterface

interface dicp_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [dicp_pkg::CFG_IDX_W-1:0]         index;
    logic [dicp_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/dicp_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle CPU picker select logic
// One-pass decision for a request beat: previous-CPU test, own-domain and
// other-domain lowest idle search, and the next idle bitmap.
// ----------------------------------------------------------------------------
module dicp_select (
    input  dicp_pkg::pick_req_t                 req,
    input  dicp_pkg::pick_cfg_t                 cfg,
    input  logic [dicp_pkg::MAX_CPUS-1:0]       idle_cpus,
    output dicp_pkg::pick_rsp_t                 rsp,
    output logic [dicp_pkg::MAX_CPUS-1:0]       idle_next
);
    import dicp_pkg::*;

    logic [MAX_CPUS-1:0] scan_mask;
    logic [MAX_CPUS-1:0] own_dom;
    logic [MAX_CPUS-1:0] other_dom;
    logic [CPU_W-1:0]    prev_idx;
    logic                prev_ok;
    logic                prev_hit;
    lowest_t             own_pick;
    lowest_t             other_pick;
    logic [SLICE_W-1:0]  own_slice;

    // Build the scan window below active_cpus (saturates at the full width)
    always_comb
    begin
        for (int i = 0; i < MAX_CPUS; i++) begin
            scan_mask[i] = (ACTIVE_W'(i) < cfg.active_cpus);
        end
    end

    assign own_dom   = req.task_domain ? cfg.little_cpu_mask : ~cfg.little_cpu_mask;
    assign other_dom = ~own_dom;
    assign prev_idx  = req.cpu_index[CPU_W-1:0];
    assign prev_ok   = ~req.cpu_index[CPU_W];
    assign prev_hit  = prev_ok && own_dom[prev_idx] && idle_cpus[prev_idx];
    assign own_slice = req.task_domain ? cfg.little_slice_ns : cfg.big_slice_ns;

    // Search both domains against the bitmap as it stands; at most one claims
    assign own_pick   = lowest_set(own_dom & req.allowed_mask & scan_mask & idle_cpus);
    assign other_pick = lowest_set(other_dom & req.allowed_mask & scan_mask & idle_cpus);

    // Decide the response and the bitmap update
    always_comb
    begin
        rsp            = '0;
        rsp.chosen_cpu = CPU_NONE;
        rsp.slice_ns   = own_slice;
        idle_next      = idle_cpus;
        unique case (req.opcode)
            OP_MARK:
            begin
                if (prev_ok)
                begin
                    idle_next[prev_idx] = 1'b1;
                end
                rsp.chosen_cpu = req.cpu_index;
                rsp.slice_ns   = '0;
            end
            OP_SELECT:
            begin
                priority if (prev_hit)
                begin
                    idle_next[prev_idx] = 1'b0;
                    rsp.chosen_cpu      = {1'b0, prev_idx};
                    rsp.claimed         = 1'b1;
                end
                else if (own_pick.found)
                begin
                    idle_next[own_pick.index] = 1'b0;
                    rsp.chosen_cpu            = {1'b0, own_pick.index};
                    rsp.claimed               = 1'b1;
                end
                else if (!cfg.strict_mode && other_pick.found)
                begin
                    idle_next[other_pick.index] = 1'b0;
                    rsp.chosen_cpu              = {1'b0, other_pick.index};
                    rsp.claimed                 = 1'b1;
                    rsp.stolen                  = 1'b1;
                end
                else
                begin
                    rsp.chosen_cpu = req.cpu_index;
                end
            end
            OP_KICK:
            begin
                if (own_pick.found)
                begin
                    idle_next[own_pick.index] = 1'b0;
                    rsp.chosen_cpu            = {1'b0, own_pick.index};
                    rsp.claimed               = 1'b1;
                end
            end
            default:
            begin
                rsp.slice_ns = '0;
            end
        endcase
    end

endmodule

/* design/domain_idle_cpu_picker_unit.sv */
`timescale 1ns / 1ps
// A request beat passes the request register, then the response register.
// Throughput: one request beat per cycle while response beats are taken; the idle
// bitmap is updated as the request register drains into the response register,
// so the next beat sees it.
// Reset (rst_n low, asynchronous): no CPU idle, active_cpus 1, all CPUs big,
// strict off, slices 20000000 / 3000000 ns, both pipeline stages empty.
`include "domain_idle_cpu_picker_unit_defines.svh"
// ----------------------------------------------------------------------------
// Idle CPU picker top level
// Request register, single-pass select logic, response register, config bank.
// ----------------------------------------------------------------------------
module domain_idle_cpu_picker_unit (
    input  logic        clk,
    input  logic        rst_n,
    dicp_req_if.sink    req,
    dicp_rsp_if.source  rsp,
    dicp_cfg_if.sink    cfg
);
    import dicp_pkg::*;

    pick_cfg_t            cfg_reg;
    logic [MAX_CPUS-1:0]  idle_reg;
    logic [MAX_CPUS-1:0]  idle_next;
    logic                 in_valid_reg;
    pick_req_t            in_req_reg;
    logic                 out_valid_reg;
    pick_rsp_t            out_rsp_reg;
    pick_rsp_t            pick_rsp;
    logic                 advance;
    logic                 fire;
    logic                 req_beat;

    // Handshake control
    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign req_beat  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Configuration bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_cpus     <= ACTIVE_W'(1);
            cfg_reg.little_cpu_mask <= '0;
            cfg_reg.strict_mode     <= 1'b0;
            cfg_reg.big_slice_ns    <= SLICE_W'(20000000);
            cfg_reg.little_slice_ns <= SLICE_W'(3000000);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ACTIVE_CPUS:  cfg_reg.active_cpus     <= cfg.data[ACTIVE_W-1:0];
                CFG_LITTLE_MASK:  cfg_reg.little_cpu_mask <= cfg.data[MAX_CPUS-1:0];
                CFG_STRICT_MODE:  cfg_reg.strict_mode     <= cfg.data[0];
                CFG_BIG_SLICE:    cfg_reg.big_slice_ns    <= cfg.data[SLICE_W-1:0];
                CFG_LITTLE_SLICE: cfg_reg.little_slice_ns <= cfg.data[SLICE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Request register: hold the accepted beat until it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_beat)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            in_req_reg.opcode       <= req.opcode;
            in_req_reg.cpu_index    <= req.cpu_index;
            in_req_reg.task_domain  <= req.task_domain;
            in_req_reg.allowed_mask <= req.allowed_mask;
        end
    end

    // Select logic
    dicp_select u_select (
        .req       (in_req_reg),
        .cfg       (cfg_reg),
        .idle_cpus (idle_reg),
        .rsp       (pick_rsp),
        .idle_next (idle_next)
    );

    // Idle bitmap: advance with each drained request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg <= '0;
        end
        else if (fire)
        begin
            idle_reg <= idle_next;
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_rsp_reg <= pick_rsp;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.chosen_cpu = out_rsp_reg.chosen_cpu;
    assign rsp.claimed    = out_rsp_reg.claimed;
    assign rsp.stolen     = out_rsp_reg.stolen;
    assign rsp.slice_ns   = out_rsp_reg.slice_ns;

    // A claim clears exactly one bit, and only one that was idle
    `DICP_ASSERT_SAME(a_claim_one_bit, fire && pick_rsp.claimed,
        ($countones(idle_reg ^ idle_next) == 1) && ((idle_next & ~idle_reg) == '0))
    // The claimed CPU was idle before the claim
    `DICP_ASSERT_SAME(a_claim_was_idle, fire && pick_rsp.claimed,
        idle_reg[pick_rsp.chosen_cpu[CPU_W-1:0]] && !pick_rsp.chosen_cpu[CPU_W])
    // A steal is always a claim and never happens in strict mode
    `DICP_ASSERT_SAME(a_steal_rules, fire && pick_rsp.stolen,
        pick_rsp.claimed && !cfg_reg.strict_mode && (in_req_reg.opcode == OP_SELECT))
    // A drained request shows up as a response beat on the next cycle
    `DICP_ASSERT_NEXT(a_fire_to_rsp, fire, out_valid_reg)

endmodule
